// ===== rtl/core/mfpic_pkg.sv =====
// Package for the MFP interrupt controller core: transaction types, command
// and register codes, and the source tables for bit positions and blocking.
// No dependencies.
package mfpic_pkg;

	// Number of interrupt sources and the width of a source index.
	localparam int NUM_SRC = 6;
	localparam int SRC_W   = 3;

	// CPU levels at or above this value hold off every dispatch.
	localparam logic [2:0] LEVEL_LIMIT = 3'd6;

	// Command codes carried in an input transaction.
	localparam logic [2:0] CMD_RAISE    = 3'd0;
	localparam logic [2:0] CMD_CHECK    = 3'd1;
	localparam logic [2:0] CMD_TA_EVENT = 3'd2;
	localparam logic [2:0] CMD_TB_EVENT = 3'd3;
	localparam logic [2:0] CMD_CLR_SVC  = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] CFG_ENABLE    = 3'd0;
	localparam logic [2:0] CFG_MASK      = 3'd1;
	localparam logic [2:0] CFG_VEC_BASE  = 3'd2;
	localparam logic [2:0] CFG_SW_EOI    = 3'd3;
	localparam logic [2:0] CFG_TA_RELOAD = 3'd4;
	localparam logic [2:0] CFG_TB_RELOAD = 3'd5;

	// Source indexes used by the timer event paths.
	localparam logic [SRC_W-1:0] SRC_TA = 3'd0;
	localparam logic [SRC_W-1:0] SRC_TB = 3'd1;

	// Input transaction.
	typedef struct packed {
		logic [2:0]  cmd;
		logic [2:0]  channel;
		logic [2:0]  cpu_level;
		logic [15:0] service_clear;
	} item_t;

	// Result transaction.
	typedef struct packed {
		logic        dispatched;
		logic [9:0]  vector_offset;
		logic [15:0] pending_bits;
		logic [15:0] service_bits;
		logic        any_pending;
		logic [7:0]  timer_a_count;
		logic [7:0]  timer_b_count;
	} result_t;

	// Outcome of the priority check.
	typedef struct packed {
		logic       hit;
		logic [3:0] pos;
	} sel_t;

	// Bit position of each source in the pending and in-service registers.
	function automatic logic [3:0] src_bitpos(input logic [SRC_W-1:0] s);
		logic [3:0] pos;
		case (s)
			3'd0:    pos = 4'd13;
			3'd1:    pos = 4'd8;
			3'd2:    pos = 4'd7;
			3'd3:    pos = 4'd6;
			3'd4:    pos = 4'd5;
			3'd5:    pos = 4'd4;
			default: pos = 4'd0;
		endcase
		return pos;
	endfunction

	// In-service bits that hold off each source.
	function automatic logic [15:0] src_block(input logic [SRC_W-1:0] s);
		logic [15:0] blk;
		case (s)
			3'd0:    blk = 16'he000;
			3'd1:    blk = 16'hff00;
			3'd2:    blk = 16'hff80;
			3'd3:    blk = 16'hffc0;
			3'd4:    blk = 16'hffe0;
			3'd5:    blk = 16'hfff0;
			default: blk = 16'h0000;
		endcase
		return blk;
	endfunction

	// A channel input sets the source's pending bit when enabled, clears it otherwise.
	function automatic logic [15:0] raise_bits(input logic [15:0] pending,
			input logic [15:0] enable, input logic [3:0] pos);
		logic [15:0] bit_m;
		bit_m = 16'(1) << pos;
		if ((enable & bit_m) != 16'h0000) begin
			return pending | bit_m;
		end
		return pending & ~bit_m;
	endfunction

endpackage

// ===== rtl/core/mfpic_prio.sv =====
// Priority check of the MFP interrupt controller: picks the first eligible
// source in the order TA, TB, FDC, KBD, TC, TD.
// Depends on mfpic_pkg.
module mfpic_prio (
	input  logic [15:0]      pending,
	input  logic [15:0]      service,
	input  logic [15:0]      mask_bits,
	input  logic [2:0]       cpu_level,
	output mfpic_pkg::sel_t  sel
);

	logic [mfpic_pkg::NUM_SRC-1:0] elig;

	// A source is eligible when pending, masked in, not held off by
	// in-service bits and allowed by the CPU level.
	always_comb begin
		for (int s = 0; s < mfpic_pkg::NUM_SRC; s++) begin
			elig[s] = pending[mfpic_pkg::src_bitpos(mfpic_pkg::SRC_W'(s))]
				&& ((service & mfpic_pkg::src_block(mfpic_pkg::SRC_W'(s))) == 16'h0000)
				&& mask_bits[mfpic_pkg::src_bitpos(mfpic_pkg::SRC_W'(s))]
				&& (cpu_level < mfpic_pkg::LEVEL_LIMIT);
		end
	end

	// The lowest eligible index wins, so scan from the far end.
	always_comb begin
		sel = '0;
		for (int s = mfpic_pkg::NUM_SRC - 1; s >= 0; s--) begin
			if (elig[s]) begin
				sel.hit = 1'b1;
				sel.pos = mfpic_pkg::src_bitpos(mfpic_pkg::SRC_W'(s));
			end
		end
	end

endmodule

// ===== rtl/core/mfp_interrupt_controller_core.sv =====
// Top level of the MFP interrupt controller core: input register, state
// update with priority check, and result register.
// Depends on mfpic_pkg and mfpic_prio.
//
//  channel   direction  handshake                  payload
//  item      in         item_valid/item_stall      mfpic_pkg::item_t
//  result    out        result_valid/result_stall  mfpic_pkg::result_t
//  config    in         cfg_we                     cfg_index, cfg_data
//
// A transaction moves from the input register into the result register, where its
// result is offered. One transaction is taken per cycle while the result does not
// stall; the state update is done in the second stage, between the two registers.
// A stalled result holds both stages; the input stalls only when the input
// register is full and cannot move on.
// Reset clears the control state, the configuration and the interrupt state.
module mfp_interrupt_controller_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  mfpic_pkg::item_t    item,
	output logic                result_valid,
	input  logic                result_stall,
	output mfpic_pkg::result_t  result,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	// Configuration registers.
	logic [15:0] enable_q;
	logic [15:0] mask_q;
	logic [3:0]  vec_base_q;
	logic        sw_eoi_q;
	logic [7:0]  ta_reload_q;
	logic [7:0]  tb_reload_q;

	// Interrupt and timer state.
	logic [15:0] pending_q;
	logic [15:0] service_q;
	logic [7:0]  count_a_q;
	logic [7:0]  count_b_q;

	// Pipeline registers.
	logic                vld_s1;
	mfpic_pkg::item_t    item_s1;
	logic                result_valid_q;
	mfpic_pkg::result_t  result_q;

	// Next-state values from the second stage.
	logic [15:0]         pending_d;
	logic [15:0]         service_d;
	logic [7:0]          count_a_d;
	logic [7:0]          count_b_d;
	logic                disp_d;
	logic [9:0]          vec_d;
	mfpic_pkg::sel_t     sel;
	logic                advance;

	// The second stage moves when the result register is free or being emptied.
	assign advance    = !result_valid_q || !result_stall;
	assign item_stall = vld_s1 && !advance;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= '0;
			mask_q      <= '0;
			vec_base_q  <= '0;
			sw_eoi_q    <= 1'b0;
			ta_reload_q <= '0;
			tb_reload_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mfpic_pkg::CFG_ENABLE:    enable_q    <= cfg_data;
				mfpic_pkg::CFG_MASK:      mask_q      <= cfg_data;
				mfpic_pkg::CFG_VEC_BASE:  vec_base_q  <= cfg_data[3:0];
				mfpic_pkg::CFG_SW_EOI:    sw_eoi_q    <= cfg_data[0];
				mfpic_pkg::CFG_TA_RELOAD: ta_reload_q <= cfg_data[7:0];
				mfpic_pkg::CFG_TB_RELOAD: tb_reload_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!vld_s1 || advance) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// Priority check on the current state.
	mfpic_prio u_prio (
		.pending   (pending_q),
		.service   (service_q),
		.mask_bits (mask_q),
		.cpu_level (item_s1.cpu_level),
		.sel       (sel)
	);

	// State update for the transaction in the input register.
	always_comb begin
		pending_d = pending_q;
		service_d = service_q;
		count_a_d = count_a_q;
		count_b_d = count_b_q;
		disp_d    = 1'b0;
		vec_d     = '0;
		unique case (item_s1.cmd)
			mfpic_pkg::CMD_RAISE: begin
				if (int'(item_s1.channel) < mfpic_pkg::NUM_SRC) begin
					pending_d = mfpic_pkg::raise_bits(pending_q, enable_q,
						mfpic_pkg::src_bitpos(item_s1.channel));
				end
			end
			mfpic_pkg::CMD_CHECK: begin
				if (sel.hit) begin
					disp_d = 1'b1;
					vec_d  = {vec_base_q, sel.pos, 2'b00};
					pending_d[sel.pos] = 1'b0;
					service_d[sel.pos] = sw_eoi_q;
				end
			end
			mfpic_pkg::CMD_TA_EVENT: begin
				if (count_a_q == 8'd1) begin
					pending_d = mfpic_pkg::raise_bits(pending_q, enable_q,
						mfpic_pkg::src_bitpos(mfpic_pkg::SRC_TA));
					count_a_d = ta_reload_q;
				end else begin
					count_a_d = count_a_q - 8'd1;
				end
			end
			mfpic_pkg::CMD_TB_EVENT: begin
				if (count_b_q == 8'd1) begin
					pending_d = mfpic_pkg::raise_bits(pending_q, enable_q,
						mfpic_pkg::src_bitpos(mfpic_pkg::SRC_TB));
					count_b_d = tb_reload_q;
				end else begin
					count_b_d = count_b_q - 8'd1;
				end
			end
			mfpic_pkg::CMD_CLR_SVC: begin
				service_d = service_q & ~item_s1.service_clear;
			end
			default: begin
			end
		endcase
	end

	// State registers and the valid bit of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q      <= '0;
			service_q      <= '0;
			count_a_q      <= '0;
			count_b_q      <= '0;
			result_valid_q <= 1'b0;
		end else if (vld_s1 && advance) begin
			pending_q      <= pending_d;
			service_q      <= service_d;
			count_a_q      <= count_a_d;
			count_b_q      <= count_b_d;
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Result payload, taken after the update.
	always_ff @(posedge clk) begin
		if (vld_s1 && advance) begin
			result_q.dispatched    <= disp_d;
			result_q.vector_offset <= vec_d;
			result_q.pending_bits  <= pending_d;
			result_q.service_bits  <= service_d;
			result_q.any_pending   <= (pending_d != 16'h0000);
			result_q.timer_a_count <= count_a_d;
			result_q.timer_b_count <= count_b_d;
		end
	end

endmodule

// ===== rtl/core/mfpic_checker.sv =====
// Port-level checks for the MFP interrupt controller core, bound to the top level.
// Depends on mfpic_pkg and mfp_interrupt_controller_core.
module mfpic_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                result_valid,
	input logic                result_stall,
	input mfpic_pkg::result_t  result
);

	// A stalled result stays offered and unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// Without a dispatch the vector offset reads zero.
	a_vec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.dispatched |-> result.vector_offset == 10'd0)
		else $error("vector offset set without dispatch");

	// The summary flag follows the pending bits.
	a_any_pending: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.any_pending == (result.pending_bits != 16'h0000))
		else $error("any_pending disagrees with pending bits");

	// A dispatched vector names one of the six source channels.
	a_vec_channel: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.dispatched |->
			(result.vector_offset[5:2] == 4'd13 || result.vector_offset[5:2] == 4'd8
			|| result.vector_offset[5:2] == 4'd7 || result.vector_offset[5:2] == 4'd6
			|| result.vector_offset[5:2] == 4'd5 || result.vector_offset[5:2] == 4'd4))
		else $error("dispatched vector names no source channel");

endmodule

bind mfp_interrupt_controller_core mfpic_checker u_mfpic_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
